### rtl/ptee_pkg.sv
// ----------------------------------------------------------------------------
// Piece table edit engine package
// Command and status codes, sequencer states and the response bundle.
// ----------------------------------------------------------------------------
package ptee_pkg;

   // Command codes carried on the request tuser field.
   localparam logic [2:0] CMD_INSERT    = 3'd0;
   localparam logic [2:0] CMD_DELETE    = 3'd1;
   localparam logic [2:0] CMD_OVERWRITE = 3'd2;
   localparam logic [2:0] CMD_READ      = 3'd3;
   localparam logic [2:0] CMD_CLEAR     = 3'd4;

   // Status codes returned with every response.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_ARG  = 3'd1;
   localparam logic [2:0] ST_NO_SITE  = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_BAD_IDX  = 3'd4;

   // Sequencer states.
   typedef enum logic [4:0] {
      S_IDLE,
      S_CHK0,
      S_CHK1,
      S_CHK2,
      S_CHK3,
      S_CHK4,
      S_RD,
      S_LOAD,
      S_CMP,
      S_SRC,
      S_WPRE,
      S_WINS,
      S_WPOST,
      S_FIN_INS,
      S_COMMIT,
      S_RDSEG,
      S_RDCAP,
      S_CLEAR,
      S_DONE
   } state_type;

   // One response as handed from the sequencer to the output register.
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] serial;
      logic [31:0] total_length;
      logic [6:0]  segment_count;
      logic [31:0] seg_offset;
      logic [31:0] seg_length;
      logic [31:0] seg_source_offset;
      logic [31:0] seg_source_id;
   } rsp_type;

endpackage

### rtl/ptee_seg_mem.sv
// ----------------------------------------------------------------------------
// Segment table memory
// Two banks of segment entries, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ptee_seg_mem #(
   parameter int AW = 6,
   parameter int DW = 128
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW:0]   wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW:0]   rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [2**(AW+1)];
   logic [DW-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ptee_seq.sv
// ----------------------------------------------------------------------------
// Piece table sequencer
// Checks each edit, then rebuilds the table entry by entry into the spare bank.
// ----------------------------------------------------------------------------
module ptee_seq
   import ptee_pkg::*;
#(
   parameter int MAX_SEGMENTS = 64,
   parameter int OFFSET_BITS  = 32,
   parameter int VW           = 32,
   parameter int AW           = 6,
   parameter int DW           = 3 * 32 + 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [2:0]    cmd,
   input  logic [31:0]   off,
   input  logic [31:0]   len,
   input  logic [5:0]    idx,
   input  logic [VW-1:0] orig,
   input  logic          rsp_free,
   output logic          ready,
   output logic          done,
   output rsp_type       rsp,
   output logic          wr_en,
   output logic [AW:0]   wr_addr,
   output logic [DW-1:0] wr_data,
   output logic [AW:0]   rd_addr,
   input  logic [DW-1:0] rd_data
);

   localparam int TW = $clog2(MAX_SEGMENTS + 1);
   localparam int CW = TW + 1;
   localparam logic [VW-1:0] ALL_ONES = '1;
   localparam logic [VW-1:0] LEN_MAX  = ALL_ONES >> (VW - OFFSET_BITS);
   localparam logic [CW-1:0] MAX_C    = CW'(MAX_SEGMENTS);

   state_type state_ff, state_in;

   logic          cur_ff, cur_in;
   logic [TW-1:0] total_ff, total_in;
   logic [VW-1:0] dlen_ff, dlen_in;
   logic [31:0]   ctr_ff, ctr_in;

   logic [2:0]    cmd_ff, cmd_in;
   logic [VW-1:0] off_ff, off_in;
   logic [VW-1:0] len_ff, len_in;
   logic [5:0]    idx_ff, idx_in;
   logic [2:0]    status_ff, status_in;
   logic [31:0]   serial_ff, serial_in;

   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] cut_ff, cut_in;
   logic [VW-1:0] cutend_ff, cutend_in;
   logic [VW-1:0] newlen_ff, newlen_in;

   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] opos_ff, opos_in;
   logic          ins_done_ff, ins_done_in;
   logic          split_ff, split_in;

   logic [VW-1:0] pos_ff, pos_in;
   logic [VW-1:0] seg_len_ff, seg_len_in;
   logic [VW-1:0] seg_src_ff, seg_src_in;
   logic [31:0]   seg_id_ff, seg_id_in;
   logic [VW-1:0] end_ff, end_in;
   logic          pre_ff, pre_in;
   logic          insh_ff, insh_in;
   logic          post_ff, post_in;
   logic [VW-1:0] prelen_ff, prelen_in;
   logic [VW-1:0] postlen_ff, postlen_in;
   logic [VW-1:0] pdelta_ff, pdelta_in;
   logic [VW-1:0] postsrc_ff, postsrc_in;

   logic [31:0]   ro_off_ff, ro_off_in;
   logic [31:0]   ro_len_ff, ro_len_in;
   logic [31:0]   ro_src_ff, ro_src_in;
   logic [31:0]   ro_id_ff, ro_id_in;

   logic          do_ins;
   logic          do_cut;
   logic [31:0]   new_id;
   logic          site_bad;
   logic          last_entry;
   logic          room;
   logic          fail;
   logic [CW-1:0] cnt_plain;
   logic [TW+5:0] idx_w;
   logic [TW+5:0] total_w;
   logic [TW+6:0] count_w;

   assign do_ins     = (cmd_ff != CMD_DELETE);
   assign do_cut     = (cmd_ff != CMD_INSERT);
   assign new_id     = ctr_ff + 32'd1;
   assign site_bad   = (cmd_ff == CMD_INSERT) ? (off_ff > dlen_ff) : (off_ff >= dlen_ff);
   assign last_entry = ((i_ff + CW'(1)) == CW'(total_ff));
   assign room       = (cnt_ff < MAX_C);
   assign cnt_plain  = cnt_ff - CW'(do_ins);
   assign fail       = (split_ff && (CW'(total_ff) >= MAX_C)) ||
                       (do_ins && (cnt_plain >= MAX_C));
   assign idx_w      = (TW + 6)'(idx_ff);
   assign total_w    = (TW + 6)'(total_ff);
   assign count_w    = (TW + 7)'(total_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (cmd)
                  CMD_INSERT, CMD_DELETE, CMD_OVERWRITE: state_in = S_CHK0;
                  CMD_READ:                              state_in = S_RDSEG;
                  CMD_CLEAR:                             state_in = S_CLEAR;
                  default:                               state_in = S_DONE;
               endcase
            end
         end
         S_CHK0: begin
            if ((len_ff == '0) || site_bad) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CHK1;
            end
         end
         S_CHK1: state_in = S_CHK2;
         S_CHK2: state_in = S_CHK3;
         S_CHK3: begin
            if (do_ins && (len_ff > (LEN_MAX - newlen_ff))) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CHK4;
            end
         end
         S_CHK4: state_in = (total_ff == '0) ? S_FIN_INS : S_RD;
         S_RD:      state_in = S_LOAD;
         S_LOAD:    state_in = S_CMP;
         S_CMP:     state_in = S_SRC;
         S_SRC:     state_in = S_WPRE;
         S_WPRE:    state_in = S_WINS;
         S_WINS:    state_in = S_WPOST;
         S_WPOST:   state_in = last_entry ? S_FIN_INS : S_RD;
         S_FIN_INS: state_in = S_COMMIT;
         S_COMMIT:  state_in = S_DONE;
         S_RDSEG:   state_in = (idx_w >= total_w) ? S_DONE : S_RDCAP;
         S_RDCAP:   state_in = S_DONE;
         S_CLEAR:   state_in = S_DONE;
         S_DONE:    state_in = rsp_free ? S_IDLE : S_DONE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Handshake and memory port outputs.
   always_comb begin
      ready   = 1'b0;
      done    = 1'b0;
      wr_en   = 1'b0;
      wr_addr = {~cur_ff, cnt_ff[AW-1:0]};
      wr_data = '0;
      rd_addr = {cur_ff, i_ff[AW-1:0]};
      unique case (state_ff)
         S_IDLE: ready = 1'b1;
         S_RDSEG: rd_addr = {cur_ff, idx_w[AW-1:0]};
         S_WPRE: begin
            wr_en   = pre_ff && room;
            wr_data = {seg_id_ff, seg_src_ff, prelen_ff, opos_ff};
         end
         S_WINS: begin
            wr_en   = insh_ff && do_ins && room;
            wr_data = {new_id, {VW{1'b0}}, len_ff, opos_ff};
         end
         S_WPOST: begin
            wr_en   = post_ff && room;
            wr_data = {seg_id_ff, postsrc_ff, postlen_ff, opos_ff};
         end
         S_FIN_INS: begin
            wr_en   = !ins_done_ff && do_ins && room;
            wr_data = {new_id, {VW{1'b0}}, len_ff, opos_ff};
         end
         S_CLEAR: begin
            wr_en   = (orig != '0);
            wr_addr = {cur_ff, {AW{1'b0}}};
            wr_data = {32'd0, {VW{1'b0}}, orig, {VW{1'b0}}};
         end
         S_DONE: done = rsp_free;
         default: ;
      endcase
   end

   // Datapath next values.
   always_comb begin
      cur_in      = cur_ff;
      total_in    = total_ff;
      dlen_in     = dlen_ff;
      ctr_in      = ctr_ff;
      cmd_in      = cmd_ff;
      off_in      = off_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      status_in   = status_ff;
      serial_in   = serial_ff;
      rem_in      = rem_ff;
      cut_in      = cut_ff;
      cutend_in   = cutend_ff;
      newlen_in   = newlen_ff;
      i_in        = i_ff;
      cnt_in      = cnt_ff;
      opos_in     = opos_ff;
      ins_done_in = ins_done_ff;
      split_in    = split_ff;
      pos_in      = pos_ff;
      seg_len_in  = seg_len_ff;
      seg_src_in  = seg_src_ff;
      seg_id_in   = seg_id_ff;
      end_in      = end_ff;
      pre_in      = pre_ff;
      insh_in     = insh_ff;
      post_in     = post_ff;
      prelen_in   = prelen_ff;
      postlen_in  = postlen_ff;
      pdelta_in   = pdelta_ff;
      postsrc_in  = postsrc_ff;
      ro_off_in   = ro_off_ff;
      ro_len_in   = ro_len_ff;
      ro_src_in   = ro_src_ff;
      ro_id_in    = ro_id_ff;
      unique case (state_ff)
         // Capture the request and clear the response fields.
         S_IDLE: begin
            if (start) begin
               cmd_in    = cmd;
               off_in    = VW'(off);
               len_in    = VW'(len);
               idx_in    = idx;
               serial_in = '0;
               ro_off_in = '0;
               ro_len_in = '0;
               ro_src_in = '0;
               ro_id_in  = '0;
               status_in = (cmd > CMD_CLEAR) ? ST_BAD_ARG : ST_OK;
            end
         end
         // Argument and site checks.
         S_CHK0: begin
            if (len_ff == '0) begin
               status_in = ST_BAD_ARG;
            end else if (site_bad) begin
               status_in = ST_NO_SITE;
            end
            rem_in = dlen_ff - off_ff;
         end
         S_CHK1: begin
            if (!do_cut) begin
               cut_in = '0;
            end else begin
               cut_in = (rem_ff > len_ff) ? len_ff : rem_ff;
            end
         end
         S_CHK2: begin
            newlen_in = dlen_ff - cut_ff;
            cutend_in = off_ff + cut_ff;
         end
         S_CHK3: begin
            if (do_ins && (len_ff > (LEN_MAX - newlen_ff))) begin
               status_in = ST_FULL;
            end
         end
         S_CHK4: begin
            if (do_ins) begin
               newlen_in = newlen_ff + len_ff;
            end
            i_in        = '0;
            cnt_in      = '0;
            opos_in     = '0;
            ins_done_in = 1'b0;
            split_in    = 1'b0;
         end
         // Fetch one old entry and find where it meets the edit.
         S_LOAD: begin
            pos_in     = rd_data[VW-1:0];
            seg_len_in = rd_data[2*VW-1:VW];
            seg_src_in = rd_data[3*VW-1:2*VW];
            seg_id_in  = rd_data[3*VW+31:3*VW];
            end_in     = rd_data[VW-1:0] + rd_data[2*VW-1:VW];
         end
         S_CMP: begin
            pre_in   = (pos_ff < off_ff);
            insh_in  = !ins_done_ff && (off_ff < end_ff);
            post_in  = (end_ff > cutend_ff);
            split_in = split_ff || ((pos_ff < off_ff) && (off_ff < end_ff));
            prelen_in = (off_ff < end_ff) ? (off_ff - pos_ff) : seg_len_ff;
            if (pos_ff >= cutend_ff) begin
               postlen_in = seg_len_ff;
               pdelta_in  = '0;
            end else begin
               postlen_in = end_ff - cutend_ff;
               pdelta_in  = cutend_ff - pos_ff;
            end
         end
         S_SRC: postsrc_in = seg_src_ff + pdelta_ff;
         // Emit the kept head, the new piece and the kept tail.
         S_WPRE: begin
            if (pre_ff) begin
               opos_in = opos_ff + prelen_ff;
               cnt_in  = cnt_ff + CW'(1);
            end
         end
         S_WINS: begin
            if (insh_ff) begin
               ins_done_in = 1'b1;
               if (do_ins) begin
                  opos_in = opos_ff + len_ff;
                  cnt_in  = cnt_ff + CW'(1);
               end
            end
         end
         S_WPOST: begin
            if (post_ff) begin
               opos_in = opos_ff + postlen_ff;
               cnt_in  = cnt_ff + CW'(1);
            end
            i_in = i_ff + CW'(1);
         end
         S_FIN_INS: begin
            if (!ins_done_ff && do_ins) begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         // Swap banks on success, keep the old table otherwise.
         S_COMMIT: begin
            if (fail) begin
               status_in = ST_FULL;
            end else begin
               cur_in    = ~cur_ff;
               total_in  = cnt_ff[TW-1:0];
               dlen_in   = newlen_ff;
               ctr_in    = new_id;
               serial_in = new_id;
            end
         end
         S_RDSEG: begin
            if (idx_w >= total_w) begin
               status_in = ST_BAD_IDX;
            end
         end
         S_RDCAP: begin
            ro_off_in = rd_data[31:0];
            ro_len_in = rd_data[VW+31:VW];
            ro_src_in = rd_data[2*VW+31:2*VW];
            ro_id_in  = rd_data[3*VW+31:3*VW];
         end
         S_CLEAR: begin
            total_in = (orig != '0) ? TW'(1) : '0;
            dlen_in  = orig;
            ctr_in   = '0;
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cur_ff      <= 1'b0;
         total_ff    <= '0;
         dlen_ff     <= '0;
         ctr_ff      <= '0;
         ins_done_ff <= 1'b0;
         split_ff    <= 1'b0;
         i_ff        <= '0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         cur_ff      <= cur_in;
         total_ff    <= total_in;
         dlen_ff     <= dlen_in;
         ctr_ff      <= ctr_in;
         ins_done_ff <= ins_done_in;
         split_ff    <= split_in;
         i_ff        <= i_in;
         cnt_ff      <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      off_ff     <= off_in;
      len_ff     <= len_in;
      idx_ff     <= idx_in;
      status_ff  <= status_in;
      serial_ff  <= serial_in;
      rem_ff     <= rem_in;
      cut_ff     <= cut_in;
      cutend_ff  <= cutend_in;
      newlen_ff  <= newlen_in;
      opos_ff    <= opos_in;
      pos_ff     <= pos_in;
      seg_len_ff <= seg_len_in;
      seg_src_ff <= seg_src_in;
      seg_id_ff  <= seg_id_in;
      end_ff     <= end_in;
      pre_ff     <= pre_in;
      insh_ff    <= insh_in;
      post_ff    <= post_in;
      prelen_ff  <= prelen_in;
      postlen_ff <= postlen_in;
      pdelta_ff  <= pdelta_in;
      postsrc_ff <= postsrc_in;
      ro_off_ff  <= ro_off_in;
      ro_len_ff  <= ro_len_in;
      ro_src_ff  <= ro_src_in;
      ro_id_ff   <= ro_id_in;
   end

   // Response bundle.
   always_comb begin
      rsp.status            = status_ff;
      rsp.serial            = serial_ff;
      rsp.total_length      = dlen_ff[31:0];
      rsp.segment_count     = count_w[6:0];
      rsp.seg_offset        = ro_off_ff;
      rsp.seg_length        = ro_len_ff;
      rsp.seg_source_offset = ro_src_ff;
      rsp.seg_source_id     = ro_id_ff;
   end

endmodule

### rtl/piece_table_edit_engine_unit.sv
// ----------------------------------------------------------------------------
// Piece table edit engine
// Keeps an ordered segment list and applies insert, delete and overwrite edits.
// ----------------------------------------------------------------------------
// Usage: each request on req_* carries a command in req_tuser and its offset,
// length and index in req_tdata. Every request yields one response on rsp_*
// with a status, the edit serial, the data length, the segment count and, for
// a read, one segment. The original data length is written on csr_*; it takes
// effect at the next clear command.
// An edit walks the whole table after its checks: it reads each segment,
// compares it with the edit and writes its kept head, the new piece where the
// edit starts, and its kept tail into the spare bank; a commit swaps the banks.
// The memory has a single registered read port and takes one write per cycle.
// A read, a clear or a request that fails its checks skips the walk. One
// request is in work at a time; req_tready is low meanwhile.
// Reset empties the table and clears the serial counter and the original
// length. A stalled rsp_tready holds the response in its register; the engine
// takes the next request but waits with the next response until it drains.
// ----------------------------------------------------------------------------
module piece_table_edit_engine_unit
   import ptee_pkg::*;
#(
   parameter int MAX_SEGMENTS = 64,
   parameter int OFFSET_BITS  = 32
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,  // offset[31:0], length[63:32], index[69:64]
   input  logic [2:0]   req_tuser,  // command[2:0]
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], serial[34:3], total_length[66:35], segment_count[73:67],
   // seg_offset[105:74], seg_length[137:106], seg_source_offset[169:138],
   // seg_source_id[201:170]
   output logic [207:0] rsp_tdata,
   // Configuration write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);

   localparam int VW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int DW = 3 * VW + 32;
   localparam logic [VW-1:0] ALL_ONES = '1;
   localparam logic [VW-1:0] LEN_MAX  = ALL_ONES >> (VW - OFFSET_BITS);

   logic [VW-1:0] orig_ff, orig_in;
   logic [VW-1:0] csr_value;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_bus;
   logic          rsp_free;
   logic          seq_ready;
   logic          seq_done;
   logic          wr_en;
   logic [AW:0]   wr_addr;
   logic [DW-1:0] wr_data;
   logic [AW:0]   rd_addr;
   logic [DW-1:0] rd_data;

   // Original length register, saturated to the offset range.
   assign csr_ready = 1'b1;
   assign csr_value = VW'(csr_data);
   always_comb begin
      orig_in = orig_ff;
      if (csr_valid) begin
         orig_in = (csr_value > LEN_MAX) ? LEN_MAX : csr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orig_ff <= '0;
      end else begin
         orig_ff <= orig_in;
      end
   end

   // Output register.
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_done) begin
         rsp_ff <= rsp_bus;
      end
   end

   assign req_tready = seq_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.seg_source_id, rsp_ff.seg_source_offset,
                        rsp_ff.seg_length, rsp_ff.seg_offset, rsp_ff.segment_count,
                        rsp_ff.total_length, rsp_ff.serial, rsp_ff.status};

   ptee_seq #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .OFFSET_BITS  (OFFSET_BITS),
      .VW           (VW),
      .AW           (AW),
      .DW           (DW)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_tvalid && seq_ready),
      .cmd      (req_tuser),
      .off      (req_tdata[31:0]),
      .len      (req_tdata[63:32]),
      .idx      (req_tdata[69:64]),
      .orig     (orig_ff),
      .rsp_free (rsp_free),
      .ready    (seq_ready),
      .done     (seq_done),
      .rsp      (rsp_bus),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   ptee_seg_mem #(
      .AW (AW),
      .DW (DW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piece table edit engine testbench
// Drives edit, read and clear requests into the engine, predicts every
// response with a behavioral copy of the segment table and checks each field.
// ----------------------------------------------------------------------------

// Behavioral segment table and the queue of predicted responses.
class piece_table_scoreboard;
   localparam int SLOTS = 64;
   bit [31:0] seg_pos[SLOTS];
   bit [31:0] seg_len[SLOTS];
   bit [31:0] seg_src[SLOTS];
   bit [31:0] seg_id[SLOTS];
   int unsigned seg_cnt;
   bit [31:0] data_len;
   bit [31:0] serial_count;
   bit [31:0] base_length;
   ptee_pkg::rsp_type pending[$];
   int errors;

   function new();
      seg_cnt = 0;
      data_len = 0;
      serial_count = 0;
      base_length = 0;
      errors = 0;
   endfunction

   function void relabel();
      bit [31:0] pos;
      pos = 0;
      for (int i = 0; i < seg_cnt; i++) begin
         seg_pos[i] = pos;
         pos += seg_len[i];
      end
   endfunction

   function void shift_up(int p);
      for (int i = seg_cnt; i > p; i--) begin
         seg_pos[i] = seg_pos[i-1];
         seg_len[i] = seg_len[i-1];
         seg_src[i] = seg_src[i-1];
         seg_id[i] = seg_id[i-1];
      end
      seg_cnt++;
   endfunction

   function void shift_down(int p);
      for (int i = p; i < seg_cnt - 1; i++) begin
         seg_pos[i] = seg_pos[i+1];
         seg_len[i] = seg_len[i+1];
         seg_src[i] = seg_src[i+1];
         seg_id[i] = seg_id[i+1];
      end
      seg_cnt--;
   endfunction

   // Creates a segment boundary at pos; returns 0 when the table is full.
   function bit split_at(bit [31:0] pos, output int where);
      bit [32:0] stop;
      bit [31:0] d;
      for (int i = 0; i < seg_cnt; i++) begin
         stop = {1'b0, seg_pos[i]} + seg_len[i];
         if (pos == seg_pos[i]) begin
            where = i;
            return 1;
         end
         if ({1'b0, pos} < stop) begin
            d = pos - seg_pos[i];
            if (seg_cnt >= SLOTS) return 0;
            shift_up(i + 1);
            seg_len[i+1] = seg_len[i] - d;
            seg_src[i+1] = seg_src[i] + d;
            seg_id[i+1] = seg_id[i];
            seg_len[i] = d;
            relabel();
            where = i + 1;
            return 1;
         end
      end
      where = seg_cnt;
      return 1;
   endfunction

   function void note_config(bit [31:0] value);
      base_length = value;
   endfunction

   // Applies one accepted request and queues the predicted response.
   function void note_request(bit [2:0] cmd, bit [31:0] off, bit [31:0] len, bit [5:0] idx);
      ptee_pkg::rsp_type r;
      bit [31:0] s_pos[SLOTS], s_len[SLOTS], s_src[SLOTS], s_id[SLOTS];
      int unsigned s_cnt;
      bit [32:0] cut, newlen;
      bit ok;
      int p;
      bit [31:0] id;
      r = '0;
      if (cmd <= ptee_pkg::CMD_OVERWRITE) begin
         id = serial_count + 1;
         newlen = data_len;
         cut = 0;
         if (len == 0) r.status = ptee_pkg::ST_BAD_ARG;
         else if ((cmd == ptee_pkg::CMD_INSERT && off > data_len) ||
                  (cmd != ptee_pkg::CMD_INSERT && off >= data_len))
            r.status = ptee_pkg::ST_NO_SITE;
         else begin
            ok = 1;
            if (cmd != ptee_pkg::CMD_INSERT) begin
               cut = data_len - off;
               if (cut > len) cut = len;
               newlen = data_len - cut;
            end
            if (cmd != ptee_pkg::CMD_DELETE) begin
               if (newlen + len > 33'hFFFF_FFFF) ok = 0;
               else newlen += len;
            end
            if (!ok) r.status = ptee_pkg::ST_FULL;
            else begin
               s_pos = seg_pos; s_len = seg_len; s_src = seg_src; s_id = seg_id;
               s_cnt = seg_cnt;
               ok = split_at(off, p);
               if (ok && cmd != ptee_pkg::CMD_INSERT) begin
                  while (cut != 0 && p < seg_cnt) begin
                     if (seg_len[p] <= cut) begin
                        cut -= seg_len[p];
                        shift_down(p);
                     end else begin
                        seg_len[p] -= cut[31:0];
                        seg_src[p] += cut[31:0];
                        cut = 0;
                     end
                  end
                  relabel();
               end
               if (ok && cmd != ptee_pkg::CMD_DELETE) begin
                  if (seg_cnt >= SLOTS || p > seg_cnt) ok = 0;
                  else begin
                     shift_up(p);
                     seg_len[p] = len;
                     seg_src[p] = 0;
                     seg_id[p] = id;
                     relabel();
                  end
               end
               if (!ok) begin
                  seg_pos = s_pos; seg_len = s_len; seg_src = s_src; seg_id = s_id;
                  seg_cnt = s_cnt;
                  r.status = ptee_pkg::ST_FULL;
               end else begin
                  serial_count = id;
                  data_len = newlen[31:0];
                  r.serial = id;
               end
            end
         end
      end else if (cmd == ptee_pkg::CMD_READ) begin
         if (idx >= seg_cnt) r.status = ptee_pkg::ST_BAD_IDX;
         else begin
            r.seg_offset = seg_pos[idx];
            r.seg_length = seg_len[idx];
            r.seg_source_offset = seg_src[idx];
            r.seg_source_id = seg_id[idx];
         end
      end else if (cmd == ptee_pkg::CMD_CLEAR) begin
         seg_cnt = 0;
         data_len = base_length;
         serial_count = 0;
         if (base_length != 0) begin
            seg_pos[0] = 0; seg_len[0] = base_length; seg_src[0] = 0; seg_id[0] = 0;
            seg_cnt = 1;
         end
      end else r.status = ptee_pkg::ST_BAD_ARG;
      r.total_length = data_len;
      r.segment_count = seg_cnt[6:0];
      pending.insert(pending.size(), r);
   endfunction

   // Compares one response with the oldest prediction.
   function void check_response(ptee_pkg::rsp_type got);
      ptee_pkg::rsp_type want;
      if (pending.size() == 0) begin
         $error("unexpected response %h", got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.status != want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status); errors++;
      end
      if (got.serial != want.serial) begin
         $error("serial: expected %0d, got %0d", want.serial, got.serial); errors++;
      end
      if (got.total_length != want.total_length) begin
         $error("total_length: expected %0d, got %0d", want.total_length, got.total_length);
         errors++;
      end
      if (got.segment_count != want.segment_count) begin
         $error("segment_count: expected %0d, got %0d", want.segment_count,
                got.segment_count);
         errors++;
      end
      if (got.seg_offset != want.seg_offset) begin
         $error("seg_offset: expected %0d, got %0d", want.seg_offset, got.seg_offset);
         errors++;
      end
      if (got.seg_length != want.seg_length) begin
         $error("seg_length: expected %0d, got %0d", want.seg_length, got.seg_length);
         errors++;
      end
      if (got.seg_source_offset != want.seg_source_offset) begin
         $error("seg_source_offset: expected %0d, got %0d", want.seg_source_offset,
                got.seg_source_offset);
         errors++;
      end
      if (got.seg_source_id != want.seg_source_id) begin
         $error("seg_source_id: expected %0d, got %0d", want.seg_source_id,
                got.seg_source_id);
         errors++;
      end
   endfunction
endclass

module testbench;
   import ptee_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [79:0]  req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [207:0] rsp_tdata;
   logic         csr_valid;
   logic         csr_ready;
   logic [31:0]  csr_data;

   piece_table_scoreboard table_model;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_off_cycles;
   longint cycle_count;

   piece_table_edit_engine_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Clock generation.
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Run limit: reports failure and ends the simulation if the cycle counter passes its limit.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 3_000_000) begin
            $display("** piece_table_edit_engine_unit: FAILED **");
            $finish;
         end
      end
   end

   // Splits the response bus into its fields, status in the lowest bits.
   function automatic rsp_type unpack_response(logic [207:0] d);
      rsp_type r;
      r.status            = d[2:0];
      r.serial            = d[34:3];
      r.total_length      = d[66:35];
      r.segment_count     = d[73:67];
      r.seg_offset        = d[105:74];
      r.seg_length        = d[137:106];
      r.seg_source_offset = d[169:138];
      r.seg_source_id     = d[201:170];
      return r;
   endfunction

   // Response side: random stalls, a long hold-off on request, checks each response.
   initial begin
      rsp_tready = 0;
      @(posedge clock iff !reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            table_model.check_response(unpack_response(rsp_tdata));
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_tready <= 0;
         end else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Sends one request and holds it until accepted.
   task automatic send_request(bit [2:0] cmd, bit [31:0] off, bit [31:0] len, bit [5:0] idx);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= {10'd0, idx, len, off};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      table_model.note_request(cmd, off, len, idx);
   endtask

   // Waits for every predicted response, then a margin for the engine to settle.
   task automatic drain();
      req_tvalid <= 0;
      while (table_model.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Writes the original length register while the engine is idle.
   task automatic write_length(bit [31:0] value);
      drain();
      csr_valid <= 1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      table_model.note_config(value);
   endtask

   // Random offset biased toward valid sites in the current data.
   function automatic bit [31:0] pick_offset();
      bit [31:0] dl;
      dl = table_model.data_len;
      case ($urandom_range(9))
         0: return $urandom;
         1: return dl;
         2: return (dl == 0) ? 0 : dl - 1;
         default: return (dl == 0) ? 0 : $urandom % dl;
      endcase
   endfunction

   function automatic bit [31:0] pick_length();
      case ($urandom_range(19))
         0: return 0;
         1: return $urandom;
         2: return 32'hFFFF_FFFF;
         default: return $urandom_range(1, 4000);
      endcase
   endfunction

   // One random request; mostly edits, with reads and the odd clear or bad code.
   task automatic random_request();
      int pick;
      bit [2:0] cmd;
      pick = $urandom_range(99);
      if (pick < 30) cmd = CMD_INSERT;
      else if (pick < 48) cmd = CMD_DELETE;
      else if (pick < 63) cmd = CMD_OVERWRITE;
      else if (pick < 95) cmd = CMD_READ;
      else if (pick < 97) cmd = CMD_CLEAR;
      else cmd = 3'($urandom_range(5, 7));
      send_request(cmd, pick_offset(), pick_length(),
                   ($urandom_range(3) == 0) ? 6'($urandom) :
                   6'($urandom_range(0, table_model.seg_cnt)));
   endtask

   initial begin
      bit [31:0] lengths[4];
      table_model = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = CMD_INSERT;
      csr_valid = 0;
      csr_data = '0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: empty table, bad codes, extremes and overflow.
      send_request(CMD_READ, 0, 0, 0);
      send_request(CMD_DELETE, 0, 5, 0);
      send_request(CMD_INSERT, 1, 5, 0);
      send_request(CMD_INSERT, 0, 0, 0);
      send_request(3'd5, 0, 1, 0);
      send_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
      write_length(100);
      send_request(CMD_CLEAR, 0, 0, 0);
      send_request(CMD_INSERT, 50, 10, 0);
      send_request(CMD_INSERT, 110, 7, 0);
      send_request(CMD_DELETE, 40, 1000, 0);
      send_request(CMD_OVERWRITE, 30, 20, 0);
      send_request(CMD_OVERWRITE, 0, 32'hFFFF_FFFF, 0);
      send_request(CMD_INSERT, 0, 1, 0);
      send_request(CMD_READ, 0, 0, 0);
      send_request(CMD_READ, 0, 0, 6'h3F);
      write_length(32'hFFFF_FFFF);
      send_request(CMD_CLEAR, 0, 0, 0);
      send_request(CMD_DELETE, 32'hFFFF_FFFE, 1, 0);
      send_request(CMD_READ, 0, 0, 0);
      // Fill the table with one-byte inserts until it reports full.
      write_length(1000);
      send_request(CMD_CLEAR, 0, 0, 0);
      for (int i = 0; i < 40; i++) send_request(CMD_INSERT, 2 * i + 1, 1, 0);
      send_request(CMD_INSERT, 3, 1, 0);
      send_request(CMD_READ, 0, 0, 63);

      // Random phases with different idle and stall rates and length settings.
      lengths = '{0, 1, 32'hFFFF_FFFF, 5000};
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         write_length((ph < 4) ? lengths[ph] : $urandom_range(1, 100000));
         send_request(CMD_CLEAR, 0, 0, 0);
         if (ph == 4) hold_off_cycles = 3000;
         for (int i = 0; i < 200; i++) random_request();
         if (ph == 5) drain();
      end
      drain();
      if (table_model.errors == 0 && table_model.pending.size() == 0)
         $display("** piece_table_edit_engine_unit: PASSED **");
      else
         $display("** piece_table_edit_engine_unit: FAILED **");
      $finish;
   end
endmodule
